// ===== rtl/lwps_pkg.sv =====
// Shared types and constants for the line/wall PID steering core.
// No dependencies; every other file of the block imports this package.
package lwps_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_GAIN_P      = 3'd0,
    REG_GAIN_D      = 3'd1,
    REG_GAIN_I      = 3'd2,
    REG_BASE_SPEED  = 3'd3,
    REG_LINE_CUTOFF = 3'd4
  } cfg_reg_e;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int GAIN_W     = 16;
  localparam int LEVEL_W    = 12;

  localparam logic [GAIN_W-1:0]  RST_GAIN_P      = 16'd11100;
  localparam logic [GAIN_W-1:0]  RST_GAIN_D      = 16'd1229;
  localparam logic [GAIN_W-1:0]  RST_GAIN_I      = 16'd41;
  localparam logic [LEVEL_W-1:0] RST_BASE_SPEED  = 12'd2048;
  localparam logic [LEVEL_W-1:0] RST_LINE_CUTOFF = 12'd500;

  // Error path
  localparam int ERR_W      = 16;
  localparam int DIFF_W     = 17;
  localparam int SUM_W      = 32;
  localparam int WIDE_ERR_W = 18;
  localparam logic signed [ERR_W-1:0]      LINE_STEP   = 16'sd100;
  localparam logic signed [WIDE_ERR_W-1:0] WALL_TARGET = 18'sd1150;
  localparam logic signed [WIDE_ERR_W-1:0] ERR_HI      = 18'sd32767;
  localparam logic signed [WIDE_ERR_W-1:0] ERR_LO      = -18'sd32768;

  // Correction path
  localparam int ACC_W  = 50;
  localparam int MAG_W  = 49;
  localparam int PD_W   = 34;
  localparam int PP_W   = 33;
  localparam int PI_W   = 49;
  localparam int Y_W    = 18;
  localparam int RECIP_W = 22;
  localparam int PROD_W  = 40;
  localparam int RECIP_SHIFT = 24;
  localparam int Q_W    = 13;
  localparam int SPD_W  = 15;
  localparam int OUT_W  = 13;

  // Dividing by 1280 is a rounding shift by 8 then a divide by 5;
  // dividing by 3200 is a rounding shift by 7 then a divide by 25.
  localparam logic [MAG_W:0] LINE_HALF  = 50'd640;
  localparam logic [MAG_W:0] WALL_HALF  = 50'd1600;
  localparam int             LINE_SHIFT = 8;
  localparam int             WALL_SHIFT = 7;
  localparam logic [Y_W-1:0] LINE_CAP   = 18'd40955;   // 8191 * 5
  localparam logic [Y_W-1:0] WALL_CAP   = 18'd204775;  // 8191 * 25
  localparam logic [RECIP_W-1:0] RECIP_LINE = 22'd3355444;  // ceil(2^24 / 5)
  localparam logic [RECIP_W-1:0] RECIP_WALL = 22'd671089;   // ceil(2^24 / 25)

  localparam logic signed [SPD_W-1:0] SPEED_HI = 15'sd3840;
  localparam logic signed [SPD_W-1:0] SPEED_LO = -15'sd3840;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_d;
    logic [GAIN_W-1:0]  gain_i;
    logic [LEVEL_W-1:0] base_speed;
    logic [LEVEL_W-1:0] line_cutoff;
  } cfg_t;

  // One classified tick handed from the front to the back.
  typedef struct packed {
    logic              wall;
    logic              on_left;
    logic [ERR_W-1:0]  err;
    logic [DIFF_W-1:0] diff;
    logic [SUM_W-1:0]  sum;
  } item_t;

endpackage

// ===== rtl/lwps_front.sv =====
// Front end: forms the steering error and updates the PID history.
// Depends on lwps_pkg; feeds lwps_queue.
module lwps_front import lwps_pkg::*; #(
  parameter int NUM_FLOOR_SENSORS = 8,
  parameter int SENSOR_BITS       = 12
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        push_i,
  input  logic                                        command_i,
  input  logic [NUM_FLOOR_SENSORS-1:0][SENSOR_BITS-1:0] floor_i,
  input  logic [SENSOR_BITS-1:0]                      wall_distance_i,
  input  logic                                        wall_on_left_i,
  input  logic [LEVEL_W-1:0]                          line_cutoff_i,
  output item_t                                       item_o
);

  localparam int NUM_LEFT = NUM_FLOOR_SENSORS / 2;
  localparam int CNT_W    = $clog2(NUM_FLOOR_SENSORS + 1);
  localparam int CMP_W    = (SENSOR_BITS > LEVEL_W) ? SENSOR_BITS : LEVEL_W;

  logic [ERR_W-1:0] prev_q, prev_d;
  logic [SUM_W-1:0] sum_q, sum_d;

  logic [CNT_W-1:0]               cnt_l, cnt_r;
  logic signed [CNT_W:0]          cnt_diff;
  logic signed [ERR_W-1:0]        err_line;
  logic signed [WIDE_ERR_W-1:0]   err_wide;
  logic signed [ERR_W-1:0]        err;
  logic signed [SUM_W:0]          sum_ext;

  always_comb begin
    cnt_l = '0;
    cnt_r = '0;
    for (int k = 0; k < NUM_FLOOR_SENSORS; k++) begin
      if (CMP_W'(floor_i[k]) < CMP_W'(line_cutoff_i)) begin
        if (k < NUM_LEFT) begin
          cnt_l = cnt_l + CNT_W'(1);
        end else begin
          cnt_r = cnt_r + CNT_W'(1);
        end
      end
    end
    cnt_diff = $signed({1'b0, cnt_l}) - $signed({1'b0, cnt_r});
    err_line = ERR_W'(cnt_diff) * LINE_STEP;

    err_wide = $signed(WIDE_ERR_W'(wall_distance_i)) - WALL_TARGET;

    priority if (!command_i) begin
      err = err_line;
    end else if (err_wide > ERR_HI) begin
      err = ERR_HI[ERR_W-1:0];
    end else if (err_wide < ERR_LO) begin
      err = ERR_LO[ERR_W-1:0];
    end else begin
      err = err_wide[ERR_W-1:0];
    end
  end

  // Integral with 32-bit saturation, dropped whenever the error is zero.
  always_comb begin
    sum_ext = $signed({sum_q[SUM_W-1], sum_q}) + (SUM_W+1)'(err);
    priority if (err == '0) begin
      sum_d = '0;
    end else if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      sum_d = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_d = sum_ext[SUM_W-1:0];
    end
    prev_d = err;
  end

  always_comb begin
    item_o.wall    = command_i;
    item_o.on_left = wall_on_left_i;
    item_o.err     = err;
    item_o.diff    = DIFF_W'($signed({err[ERR_W-1], err}) - $signed({prev_q[ERR_W-1], prev_q}));
    item_o.sum     = sum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      sum_q  <= '0;
    end else if (push_i) begin
      prev_q <= prev_d;
      sum_q  <= sum_d;
    end
  end

`ifndef ASSERT_OFF
  a_sum_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && (err == '0)) |=> (sum_q == '0))
    else $error("integral not cleared after a zero error");

  a_prev_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |=> (prev_q == $past(err)))
    else $error("previous error not updated");
`endif

endmodule

// ===== rtl/lwps_queue.sv =====
// Short queue that decouples the front end from the arithmetic back end.
// Depends on lwps_pkg for the entry type and depth.
module lwps_queue import lwps_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= CNT_W'(QUEUE_DEPTH)) && !(push_i && full_o))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("queue underflow");
`endif

endmodule

// ===== rtl/lwps_back.sv =====
// Back end: PID products, rounding division and wheel speed clamp in six stages.
// Depends on lwps_pkg; takes items from lwps_queue.
module lwps_back import lwps_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  logic                     valid_i,
  input  item_t                    item_i,
  output logic                     pop_o,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic signed [OUT_W-1:0]  left_o,
  output logic signed [OUT_W-1:0]  right_o
);

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic adv1, adv2, adv3, adv4, adv5, adv6;

  // Stage 1: products
  logic signed [PD_W-1:0] pd_q;
  logic signed [PP_W-1:0] pp_q;
  logic signed [PI_W-1:0] pi_q;
  logic                   wall1_q, left1_q;
  // Stage 2: accumulated sum
  logic signed [ACC_W-1:0] acc_q;
  logic                    wall2_q, left2_q;
  // Stage 3: magnitude and final sign
  logic [MAG_W-1:0] mag_q;
  logic             wall3_q, sgn3_q;
  // Stage 4: shifted and capped dividend
  logic [Y_W-1:0]   y_q;
  logic             wall4_q, sgn4_q;
  // Stage 5: reciprocal product
  logic [PROD_W-1:0] prod_q;
  logic              sgn5_q;
  // Stage 6: output
  logic signed [OUT_W-1:0] left_q, right_q;

  logic [MAG_W:0]          rnd_sum;
  logic [MAG_W:0]          shifted;
  logic [Y_W-1:0]          cap;
  logic [Q_W-1:0]          quo;
  logic signed [SPD_W-1:0] corr, base_s, left_w, right_w;
  logic signed [OUT_W-1:0] left_c, right_c;

  // A stage takes new data when it is empty or its content moves on.
  assign adv6  = !v6_q || ready_i;
  assign adv5  = !v5_q || adv6;
  assign adv4  = !v4_q || adv5;
  assign adv3  = !v3_q || adv4;
  assign adv2  = !v2_q || adv3;
  assign adv1  = !v1_q || adv2;
  assign pop_o = valid_i && adv1;

  assign valid_o = v6_q;
  assign left_o  = left_q;
  assign right_o = right_q;

  always_comb begin
    rnd_sum = {1'b0, mag_q} + (wall3_q ? WALL_HALF : LINE_HALF);
    shifted = wall3_q ? (rnd_sum >> WALL_SHIFT) : (rnd_sum >> LINE_SHIFT);
    cap     = wall3_q ? WALL_CAP : LINE_CAP;
  end

  always_comb begin
    quo     = prod_q[RECIP_SHIFT +: Q_W];
    corr    = sgn5_q ? -$signed(SPD_W'(quo)) : $signed(SPD_W'(quo));
    base_s  = $signed(SPD_W'(cfg_i.base_speed));
    left_w  = base_s + corr;
    right_w = base_s - corr;
    priority if (left_w > SPEED_HI) begin
      left_c = SPEED_HI[OUT_W-1:0];
    end else if (left_w < SPEED_LO) begin
      left_c = SPEED_LO[OUT_W-1:0];
    end else begin
      left_c = left_w[OUT_W-1:0];
    end
    priority if (right_w > SPEED_HI) begin
      right_c = SPEED_HI[OUT_W-1:0];
    end else if (right_w < SPEED_LO) begin
      right_c = SPEED_LO[OUT_W-1:0];
    end else begin
      right_c = right_w[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
      if (adv5) v5_q <= v4_q;
      if (adv6) v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && valid_i) begin
      pd_q    <= $signed({1'b0, cfg_i.gain_d}) * $signed(item_i.diff);
      pp_q    <= $signed({1'b0, cfg_i.gain_p}) * $signed(item_i.err);
      pi_q    <= $signed({1'b0, cfg_i.gain_i}) * $signed(item_i.sum);
      wall1_q <= item_i.wall;
      left1_q <= item_i.on_left;
    end
    if (adv2 && v1_q) begin
      acc_q   <= ACC_W'(pd_q) + ACC_W'(pp_q) + ACC_W'(pi_q);
      wall2_q <= wall1_q;
      left2_q <= left1_q;
    end
    if (adv3 && v2_q) begin
      mag_q   <= acc_q[ACC_W-1] ? MAG_W'(-acc_q) : MAG_W'(acc_q);
      wall3_q <= wall2_q;
      // Left wheel gets base plus the signed correction; line mode and a
      // wall on the right both flip the sign.
      sgn3_q  <= acc_q[ACC_W-1] ^ (!wall2_q || !left2_q);
    end
    if (adv4 && v3_q) begin
      y_q     <= (shifted > (MAG_W+1)'(cap)) ? cap : shifted[Y_W-1:0];
      wall4_q <= wall3_q;
      sgn4_q  <= sgn3_q;
    end
    if (adv5 && v4_q) begin
      prod_q  <= PROD_W'(y_q) * PROD_W'(wall4_q ? RECIP_WALL : RECIP_LINE);
      sgn5_q  <= sgn4_q;
    end
    if (adv6 && v5_q) begin
      left_q  <= left_c;
      right_q <= right_c;
    end
  end

`ifndef ASSERT_OFF
  a_y_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> (y_q <= WALL_CAP))
    else $error("dividend above cap");

  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v6_q |-> (($signed(left_q) <= $signed(SPEED_HI[OUT_W-1:0]))
           && ($signed(left_q) >= $signed(SPEED_LO[OUT_W-1:0]))
           && ($signed(right_q) <= $signed(SPEED_HI[OUT_W-1:0]))
           && ($signed(right_q) >= $signed(SPEED_LO[OUT_W-1:0]))))
    else $error("wheel speed outside clamp");
`endif

endmodule

// ===== rtl/line_wall_pid_steering_core.sv =====
// Top level of the line/wall PID steering core: config registers and stream ports.
// Depends on lwps_pkg, lwps_front, lwps_queue and lwps_back.
//
//   channel    | direction | handshake              | contents
//   s_axis     | in        | tvalid/tready          | one control tick (mode, sensors)
//   m_axis     | out       | tvalid/tready          | left and right wheel speed
//   cfg        | in        | cfg_we_i               | register write, no read-back
//
// One tick enters per cycle while the queue is not full.
// The front updates the previous error and integral in the cycle of acceptance.
// A two-entry queue and a six-stage back pipeline take stalls independently.
// Reset clears the history, the queue and the pipeline and loads default gains.
module line_wall_pid_steering_core import lwps_pkg::*; #(
  parameter int NUM_FLOOR_SENSORS = 8,
  parameter int SENSOR_BITS       = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: floor_0 .. floor_N-1, wall_distance, wall_on_left, zero fill
  input  logic [((((NUM_FLOOR_SENSORS + 1) * SENSOR_BITS + 1) + 7) / 8) * 8 - 1:0]
                                s_axis_tdata,
  // tuser: command
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: left_speed, right_speed, zero fill
  output logic [31:0]           m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int FLOOR_BITS = NUM_FLOOR_SENSORS * SENSOR_BITS;

  cfg_t  cfg_q;
  item_t front_item, queue_item;
  logic  queue_full, queue_valid, pop, push;
  logic signed [OUT_W-1:0] left_speed, right_speed;
  logic [NUM_FLOOR_SENSORS-1:0][SENSOR_BITS-1:0] floor;

  assign floor         = s_axis_tdata[FLOOR_BITS-1:0];
  assign s_axis_tready = !queue_full;
  assign push          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p      <= RST_GAIN_P;
      cfg_q.gain_d      <= RST_GAIN_D;
      cfg_q.gain_i      <= RST_GAIN_I;
      cfg_q.base_speed  <= RST_BASE_SPEED;
      cfg_q.line_cutoff <= RST_LINE_CUTOFF;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_GAIN_P:      cfg_q.gain_p      <= cfg_wdata_i;
        REG_GAIN_D:      cfg_q.gain_d      <= cfg_wdata_i;
        REG_GAIN_I:      cfg_q.gain_i      <= cfg_wdata_i;
        REG_BASE_SPEED:  cfg_q.base_speed  <= cfg_wdata_i[LEVEL_W-1:0];
        REG_LINE_CUTOFF: cfg_q.line_cutoff <= cfg_wdata_i[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  lwps_front #(
    .NUM_FLOOR_SENSORS (NUM_FLOOR_SENSORS),
    .SENSOR_BITS       (SENSOR_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .command_i       (s_axis_tuser),
    .floor_i         (floor),
    .wall_distance_i (s_axis_tdata[FLOOR_BITS +: SENSOR_BITS]),
    .wall_on_left_i  (s_axis_tdata[FLOOR_BITS + SENSOR_BITS]),
    .line_cutoff_i   (cfg_q.line_cutoff),
    .item_o          (front_item)
  );

  lwps_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (front_item),
    .full_o      (queue_full),
    .pop_i       (pop),
    .valid_o     (queue_valid),
    .item_o      (queue_item)
  );

  lwps_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (queue_valid),
    .item_i  (queue_item),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .left_o  (left_speed),
    .right_o (right_speed)
  );

  assign m_axis_tdata = {6'b0, right_speed, left_speed};

endmodule
